### hw/rtl/bhs_pkg.sv
// Shared types and constants of the bucketed hash set.
package bhs_pkg;
	localparam int Buckets = 64;
	localparam int Slots = 16;
	localparam int KeyBits = 32;
	localparam int BktW = $clog2(Buckets);
	localparam int SlotW = $clog2(Slots);
	localparam int AddrW = BktW + SlotW;
	localparam int FillW = 5;
	localparam int TotW = 11;
	localparam int CntW = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [KeyBits-1:0] key;
		logic [BktW-1:0] bkt;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [FillW-1:0] fill;
		logic [TotW-1:0] total;
	} res_t;
endpackage

### hw/rtl/bhs_front.sv
// Front end: accepts transactions and computes the bucket by serial modulo.
module bhs_front import bhs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [CntW-1:0] bucket_count,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_op,
	input logic [KeyBits-1:0] in_key,
	output logic req_valid,
	input logic req_ready,
	output req_t req
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV = 2'd1;
	localparam logic [1:0] S_OUT = 2'd2;

	logic [1:0] state_q;
	logic [KeyBits-1:0] key_q;
	logic [KeyBits-1:0] shf_q;
	logic [1:0] op_q;
	logic [CntW:0] rem_q;
	logic [CntW:0] div_q;
	logic [$clog2(KeyBits+1)-1:0] cnt_q;
	logic [CntW:0] trial;

	assign trial = {rem_q[CntW-1:0], shf_q[KeyBits-1]};
	assign in_ready = (state_q == S_IDLE);
	assign req_valid = (state_q == S_OUT);
	assign req.op = op_q;
	assign req.key = key_q;
	assign req.bkt = rem_q[BktW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV;
						key_q <= in_key;
						shf_q <= in_key;
						op_q <= in_op;
						rem_q <= '0;
						cnt_q <= '0;
						if (bucket_count == '0) begin
							div_q <= (CntW+1)'(1);
						end else if (bucket_count > CntW'(Buckets)) begin
							div_q <= (CntW+1)'(Buckets);
						end else begin
							div_q <= {1'b0, bucket_count};
						end
					end
				end
				S_DIV: begin
					shf_q <= shf_q << 1;
					rem_q <= (trial >= div_q) ? trial - div_q : trial;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ($clog2(KeyBits+1))'(KeyBits-1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (req_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/bhs_fifo.sv
// Two-entry queue between front and back ends.
module bhs_fifo import bhs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input req_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output req_t rd_data
);
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

### hw/rtl/bhs_back.sv
// Back end: walks the slots of a bucket and applies the operation.
module bhs_back import bhs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic res_valid,
	input logic res_ready,
	output res_t res
);
	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_APPLY = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [KeyBits-1:0] key_mem [Buckets*Slots];
	logic [Slots-1:0] valid_mem [Buckets];
	logic [FillW-1:0] fill_mem [Buckets];

	logic [2:0] state_q;
	logic [BktW-1:0] clr_q;
	req_t r_q;
	logic [Slots-1:0] vrow_q;
	logic [FillW-1:0] fill_q;
	logic [TotW-1:0] total_q;
	logic [SlotW:0] idx_q;
	logic [SlotW-1:0] rd_slot_s1;
	logic rd_en_s1;
	logic [KeyBits-1:0] rkey_q;
	logic hit_q;
	logic [SlotW-1:0] hit_slot_q;
	logic free_q;
	logic [SlotW-1:0] free_slot_q;
	logic [1:0] st_q;
	logic [AddrW-1:0] rd_addr;
	logic row_we;
	logic [BktW-1:0] row_addr;
	logic [Slots-1:0] row_wdata;
	logic [FillW-1:0] fill_wdata;

	assign rd_addr = {r_q.bkt, idx_q[SlotW-1:0]};
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res.status = st_q;
	assign res.found = hit_q;
	assign res.fill = fill_q;
	assign res.total = total_q;

	always_comb begin
		row_we = 1'b0;
		row_addr = r_q.bkt;
		row_wdata = vrow_q;
		fill_wdata = fill_q;
		if (state_q == S_CLR) begin
			row_we = 1'b1;
			row_addr = clr_q;
			row_wdata = '0;
			fill_wdata = '0;
		end else if (state_q == S_APPLY) begin
			if (r_q.op == OP_INSERT && !hit_q && free_q) begin
				row_we = 1'b1;
				row_wdata = vrow_q | (Slots'(1) << free_slot_q);
				fill_wdata = fill_q + 1'b1;
			end else if (r_q.op == OP_DELETE && hit_q) begin
				row_we = 1'b1;
				row_wdata = vrow_q & ~(Slots'(1) << hit_slot_q);
				fill_wdata = fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rkey_q <= key_mem[rd_addr];
		if (state_q == S_APPLY && r_q.op == OP_INSERT && !hit_q && free_q) begin
			key_mem[{r_q.bkt, free_slot_q}] <= r_q.key;
		end
		if (row_we) begin
			valid_mem[row_addr] <= row_wdata;
			fill_mem[row_addr] <= fill_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			total_q <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= (state_q == S_SCAN) && !idx_q[SlotW];
			rd_slot_s1 <= idx_q[SlotW-1:0];
			if (rd_en_s1 && vrow_q[rd_slot_s1] && rkey_q == r_q.key && !hit_q) begin
				hit_q <= 1'b1;
				hit_slot_q <= rd_slot_s1;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BktW'(Buckets-1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						r_q <= req;
						vrow_q <= valid_mem[req.bkt];
						fill_q <= fill_mem[req.bkt];
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q[SlotW]) begin
						state_q <= S_WAIT;
					end else begin
						if (!vrow_q[idx_q[SlotW-1:0]] && !free_q) begin
							free_q <= 1'b1;
							free_slot_q <= idx_q[SlotW-1:0];
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WAIT: state_q <= S_APPLY;
				S_APPLY: begin
					state_q <= S_OUT;
					if (r_q.op == OP_INSERT) begin
						if (hit_q) begin
							st_q <= ST_DUP;
						end else if (free_q) begin
							st_q <= ST_DONE;
							fill_q <= fill_q + 1'b1;
							total_q <= total_q + 1'b1;
						end else begin
							st_q <= ST_FULL;
						end
					end else if (r_q.op == OP_DELETE) begin
						if (hit_q) begin
							st_q <= ST_DONE;
							fill_q <= fill_q - 1'b1;
							total_q <= total_q - 1'b1;
						end else begin
							st_q <= ST_ABSENT;
						end
					end else begin
						st_q <= hit_q ? ST_DONE : ST_ABSENT;
					end
				end
				S_OUT: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/bucketed_hash_set.sv
// Top level of the bucketed hash set.
// Usage: each s_axis transaction carries an operation (insert, delete or
// search) and a 32-bit key. Each request yields exactly one m_axis transaction
// with status, found flag, bucket fill and total key count.
// The front end finds the bucket with a bit-serial modulo. A two-entry
// queue then hands the request to the back end, which reads the bucket's
// 16 slots one per cycle from the key memory and applies the change. The
// front end can divide the next key while the back end works, so the front
// end's modulo sets the throughput. After reset the back end clears its 64
// bucket rows, one per cycle, before it takes the first request. A stalled
// m_axis holds the result and backs up the queue and then s_axis.
// bucket_count is written through cfg_we and cfg_data; the user must write
// it only while idle, which the block does not enforce. Zero acts as one,
// values 65 to 127 act as 64, and only cfg_data[6:0] is kept.
module bucketed_hash_set import bhs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // operation[1:0], key[33:2], zero fill
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [23:0] m_axis_tdata // status[1:0], found[2], bucket_fill[7:3], total_keys[18:8]
);
	logic [CntW-1:0] bucket_count_q;
	logic fq_wv, fq_wr, fq_rv, fq_rr;
	req_t fq_wd, fq_rd;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CntW'(Buckets);
		end else if (cfg_we) begin
			bucket_count_q <= cfg_data[CntW-1:0];
		end
	end

	bhs_front u_front (
		.clk, .arst_n, .bucket_count(bucket_count_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tdata[1:0]), .in_key(s_axis_tdata[33:2]),
		.req_valid(fq_wv), .req_ready(fq_wr), .req(fq_wd)
	);

	bhs_fifo u_fifo (
		.clk, .arst_n, .wr_valid(fq_wv), .wr_ready(fq_wr), .wr_data(fq_wd),
		.rd_valid(fq_rv), .rd_ready(fq_rr), .rd_data(fq_rd)
	);

	bhs_back u_back (
		.clk, .arst_n, .req_valid(fq_rv), .req_ready(fq_rr), .req(fq_rd),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'd0, res.total, res.fill, res.found, res.status};

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.fill <= FillW'(Slots)) else $error("fill out of range");
	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status == ST_DUP |-> res.found) else $error("dup without hit");
	a_full_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status == ST_FULL |-> !res.found && res.fill == FillW'(Slots))
		else $error("full inconsistent");
`endif
endmodule
